// ===== rtl/wpf_pkg.sv =====
// Shared types and constants for the window placement fit-to-monitor block.
// No dependencies; every other file refers to it by scoped names.
package wpf_pkg;

  // Field widths
  localparam int unsigned COORD_W   = 21;  // window / area left and top
  localparam int unsigned EXT_W     = 17;  // signed width / height on input
  localparam int unsigned SIZE_W    = 16;  // stored window / area size
  localparam int unsigned RES_W     = 22;  // adjusted position on output
  localparam int unsigned OV_W      = 32;  // overlap area
  localparam int unsigned DIFF_W    = 23;  // magnitude of doubled center delta
  localparam int unsigned DIST_W    = 46;  // squared center distance

  // Configuration port
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] MIN_WIDTH_RST  = 16'd320;
  localparam logic [CFG_W-1:0] MIN_HEIGHT_RST = 16'd200;

  // Coordinate limits of the placement check
  localparam logic signed [COORD_W-1:0] MAX_COORD = 21'sd1000000;
  localparam logic signed [COORD_W-1:0] MIN_COORD = -21'sd1000000;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Item class assigned by the front
  typedef enum logic [1:0] {
    OP_PLACE,   // window placement, starts a query
    OP_AREA,    // usable work area
    OP_SKIP     // work area with no width or height
  } op_t;

  // Classified word passed from front to back
  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [EXT_W-1:0]   ext_w;
    logic signed [EXT_W-1:0]   ext_h;
    logic                      maxf;
    logic                      last;
    logic                      sane;
  } item_t;

endpackage

// ===== rtl/wpf_front.sv =====
// Front of the placement fitter: accepts input words, holds the limit registers,
// classifies each word and checks placements. Depends on wpf_pkg.
module wpf_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpf_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic signed [wpf_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [wpf_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [wpf_pkg::EXT_W-1:0]   in_extent_w,
  input  logic signed [wpf_pkg::EXT_W-1:0]   in_extent_h,
  input  logic                               in_is_maximized,
  input  logic                               in_last,
  output logic                               push_valid,
  output wpf_pkg::item_t                     push_item,
  input  logic                               queue_full
);

  logic [wpf_pkg::CFG_W-1:0] min_width_r, min_width_nxt;
  logic [wpf_pkg::CFG_W-1:0] min_height_r, min_height_nxt;
  logic                      hold_valid_r, hold_valid_nxt;
  wpf_pkg::item_t            hold_item_r, hold_item_nxt;
  logic                      sane;
  logic                      usable;

  // Decode limit register writes
  always_comb begin
    min_width_nxt  = min_width_r;
    min_height_nxt = min_height_r;
    if (cfg_we) begin
      if (cfg_index == wpf_pkg::CFG_MIN_WIDTH) begin
        min_width_nxt = cfg_wdata;
      end
      if (cfg_index == wpf_pkg::CFG_MIN_HEIGHT) begin
        min_height_nxt = cfg_wdata;
      end
    end
  end

  // Check the placement
  assign sane = (in_extent_w >= $signed({1'b0, min_width_r})) &&
                (in_extent_h >= $signed({1'b0, min_height_r})) &&
                (in_pos_x >= wpf_pkg::MIN_COORD) && (in_pos_x <= wpf_pkg::MAX_COORD) &&
                (in_pos_y >= wpf_pkg::MIN_COORD) && (in_pos_y <= wpf_pkg::MAX_COORD);

  assign usable = (in_extent_w > 0) && (in_extent_h > 0);

  // Stall only while the held word cannot move into the queue
  assign in_stall   = hold_valid_r && queue_full;
  assign push_valid = hold_valid_r;
  assign push_item  = hold_item_r;

  // Classify the incoming word
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_item_nxt  = hold_item_r;
    if (!in_stall) begin
      hold_valid_nxt      = in_valid;
      hold_item_nxt.pos_x = in_pos_x;
      hold_item_nxt.pos_y = in_pos_y;
      hold_item_nxt.ext_w = in_extent_w;
      hold_item_nxt.ext_h = in_extent_h;
      hold_item_nxt.maxf  = in_is_maximized;
      hold_item_nxt.last  = in_last;
      hold_item_nxt.sane  = sane;
      if (!in_kind) begin
        hold_item_nxt.op = wpf_pkg::OP_PLACE;
      end else if (usable) begin
        hold_item_nxt.op = wpf_pkg::OP_AREA;
      end else begin
        hold_item_nxt.op = wpf_pkg::OP_SKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_width_r  <= wpf_pkg::MIN_WIDTH_RST;
      min_height_r <= wpf_pkg::MIN_HEIGHT_RST;
      hold_valid_r <= 1'b0;
    end else begin
      min_width_r  <= min_width_nxt;
      min_height_r <= min_height_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_item_r <= hold_item_nxt;
  end

endmodule

// ===== rtl/wpf_queue.sv =====
// Short word queue between the front and the back of the placement fitter.
// Depends on wpf_pkg for the word type.
module wpf_queue #(
  parameter int unsigned Depth = wpf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  wpf_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output wpf_pkg::item_t pop_item
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wpf_pkg::item_t  mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full      = (count_r == CntW'(Depth));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/wpf_back.sv =====
// Back of the placement fitter: geometry, multiply, best-area select and result
// stages, plus the stored window and search state. Depends on wpf_pkg.
module wpf_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  wpf_pkg::item_t                     q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_ok,
  output logic signed [wpf_pkg::RES_W-1:0]   out_x,
  output logic signed [wpf_pkg::RES_W-1:0]   out_y,
  output logic [wpf_pkg::SIZE_W-1:0]         out_w,
  output logic [wpf_pkg::SIZE_W-1:0]         out_h,
  output logic                               out_maximized
);

  localparam int unsigned CW   = wpf_pkg::COORD_W;
  localparam int unsigned EW   = wpf_pkg::EXT_W;
  localparam int unsigned SW   = wpf_pkg::SIZE_W;
  localparam int unsigned RW   = wpf_pkg::RES_W;
  localparam int unsigned SUMW = CW + 2;   // right and bottom edges
  localparam int unsigned DBLW = CW + 3;   // doubled centers
  localparam int unsigned DFW  = wpf_pkg::DIFF_W;
  localparam int unsigned DSW  = wpf_pkg::DIST_W;
  localparam int unsigned OVW  = wpf_pkg::OV_W;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [SW-1:0]        w;
    logic [SW-1:0]        h;
    logic                 maxf;
    logic                 sane;
  } win_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [SW-1:0]        w;
    logic [SW-1:0]        h;
  } rect_t;

  logic advance;

  // Stored window
  win_t win_r, win_nxt;

  // Geometry stage
  logic                 a_valid_r;
  wpf_pkg::op_t         a_op_r;
  logic                 a_last_r;
  logic [SW-1:0]        a_ow_r, a_oh_r;
  logic [DFW-1:0]       a_ux_r, a_uy_r;
  rect_t                a_area_r;
  win_t                 a_win_r;

  // Multiply stage
  logic                 b_valid_r;
  wpf_pkg::op_t         b_op_r;
  logic                 b_last_r;
  logic [OVW-1:0]       b_ov_r;
  logic [DSW-1:0]       b_sqx_r, b_sqy_r;
  rect_t                b_area_r;
  win_t                 b_win_r;

  // Search state
  logic                 have_best_r, have_best_nxt;
  logic [OVW-1:0]       best_ov_r, best_ov_nxt;
  logic [DSW-1:0]       best_dist_r, best_dist_nxt;
  rect_t                best_area_r, best_area_nxt;

  // Result snapshot stage
  logic                 s_valid_r;
  logic                 s_ok_r;
  logic                 s_zero_r;
  rect_t                s_area_r;
  win_t                 s_win_r;

  // Output register
  logic                 out_valid_r;
  logic                 out_ok_r;
  logic signed [RW-1:0] out_x_r, out_y_r;
  logic [SW-1:0]        out_w_r, out_h_r;
  logic                 out_max_r;

  // Move the whole back pipeline unless a finished result is held
  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && q_valid;

  // ---------------------------------------------------------------------------
  // Geometry stage
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]   q_px, q_py, lft, top;
  logic signed [EW-1:0]   q_ew, q_eh;
  logic signed [SUMW-1:0] w_right, w_bot, a_right, a_bot, right, bot, span_x, span_y;
  logic signed [DBLW-1:0] cen_wx, cen_wy, cen_ax, cen_ay, dx, dy, adx, ady;
  logic                   overlap;
  logic                   is_place;

  assign q_px     = q_item.pos_x;
  assign q_py     = q_item.pos_y;
  assign q_ew     = q_item.ext_w;
  assign q_eh     = q_item.ext_h;
  assign is_place = q_valid && (q_item.op == wpf_pkg::OP_PLACE);

  // Load the window on a placement word
  always_comb begin
    win_nxt = win_r;
    if (is_place) begin
      win_nxt.x    = q_px;
      win_nxt.y    = q_py;
      win_nxt.w    = q_ew[SW-1:0];
      win_nxt.h    = q_eh[SW-1:0];
      win_nxt.maxf = q_item.maxf;
      win_nxt.sane = q_item.sane;
    end
  end

  // Intersection spans
  assign w_right = $signed({{2{win_r.x[CW-1]}}, win_r.x}) + $signed({{(SUMW-SW){1'b0}}, win_r.w});
  assign w_bot   = $signed({{2{win_r.y[CW-1]}}, win_r.y}) + $signed({{(SUMW-SW){1'b0}}, win_r.h});
  assign a_right = $signed({{2{q_px[CW-1]}}, q_px}) + $signed({{(SUMW-EW){q_ew[EW-1]}}, q_ew});
  assign a_bot   = $signed({{2{q_py[CW-1]}}, q_py}) + $signed({{(SUMW-EW){q_eh[EW-1]}}, q_eh});
  assign lft     = (win_r.x > q_px) ? win_r.x : q_px;
  assign top     = (win_r.y > q_py) ? win_r.y : q_py;
  assign right   = (w_right < a_right) ? w_right : a_right;
  assign bot     = (w_bot < a_bot) ? w_bot : a_bot;
  assign span_x  = right - $signed({{2{lft[CW-1]}}, lft});
  assign span_y  = bot - $signed({{2{top[CW-1]}}, top});
  assign overlap = (span_x > 0) && (span_y > 0);

  // Doubled center deltas and their magnitudes
  assign cen_wx = $signed({{2{win_r.x[CW-1]}}, win_r.x, 1'b0}) +
                  $signed({{(DBLW-SW){1'b0}}, win_r.w});
  assign cen_wy = $signed({{2{win_r.y[CW-1]}}, win_r.y, 1'b0}) +
                  $signed({{(DBLW-SW){1'b0}}, win_r.h});
  assign cen_ax = $signed({{2{q_px[CW-1]}}, q_px, 1'b0}) +
                  $signed({{(DBLW-EW){q_ew[EW-1]}}, q_ew});
  assign cen_ay = $signed({{2{q_py[CW-1]}}, q_py, 1'b0}) +
                  $signed({{(DBLW-EW){q_eh[EW-1]}}, q_eh});
  assign dx     = cen_wx - cen_ax;
  assign dy     = cen_wy - cen_ay;
  assign adx    = dx[DBLW-1] ? -dx : dx;
  assign ady    = dy[DBLW-1] ? -dy : dy;

  // ---------------------------------------------------------------------------
  // Select stage: compare against the best area and snapshot on last
  // ---------------------------------------------------------------------------
  logic [DSW:0]   dist_sum;
  logic [DSW-1:0] sq_dist;
  logic           better;
  logic           cur_have;
  logic [OVW-1:0] cur_ov;
  logic [DSW-1:0] cur_dist;
  rect_t          cur_area;
  logic           b_take;

  assign b_take   = advance && b_valid_r;
  assign dist_sum = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
  assign sq_dist  = dist_sum[DSW-1:0];
  assign better   = (b_op_r == wpf_pkg::OP_AREA) &&
                    (!have_best_r || (b_ov_r > best_ov_r) ||
                     ((b_ov_r == best_ov_r) && (b_ov_r == '0) && (sq_dist < best_dist_r)));

  // Search state after this word, before any clear on last
  always_comb begin
    cur_have = have_best_r;
    cur_ov   = best_ov_r;
    cur_dist = best_dist_r;
    cur_area = best_area_r;
    if (b_op_r == wpf_pkg::OP_PLACE) begin
      cur_have = 1'b0;
      cur_ov   = '0;
      cur_dist = '1;
      cur_area = '0;
    end else if (better) begin
      cur_have = 1'b1;
      cur_ov   = b_ov_r;
      cur_dist = sq_dist;
      cur_area = b_area_r;
    end
  end

  // Update the search; drop it after a result
  always_comb begin
    have_best_nxt = have_best_r;
    best_ov_nxt   = best_ov_r;
    best_dist_nxt = best_dist_r;
    best_area_nxt = best_area_r;
    if (b_take) begin
      if (b_last_r) begin
        have_best_nxt = 1'b0;
        best_ov_nxt   = '0;
        best_dist_nxt = '1;
        best_area_nxt = '0;
      end else begin
        have_best_nxt = cur_have;
        best_ov_nxt   = cur_ov;
        best_dist_nxt = cur_dist;
        best_area_nxt = cur_area;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: cut the size, then center or clamp
  // ---------------------------------------------------------------------------
  logic [SW-1:0]        r_w, r_h, slack_w, slack_h;
  logic signed [RW-1:0] ax, ay, wx, wy, cen_x, cen_y, hi_x, hi_y, lo_x, lo_y;
  logic signed [RW-1:0] fit_x, fit_y;

  assign r_w     = (s_win_r.w < s_area_r.w) ? s_win_r.w : s_area_r.w;
  assign r_h     = (s_win_r.h < s_area_r.h) ? s_win_r.h : s_area_r.h;
  assign slack_w = s_area_r.w - r_w;
  assign slack_h = s_area_r.h - r_h;
  assign ax      = $signed({s_area_r.x[CW-1], s_area_r.x});
  assign ay      = $signed({s_area_r.y[CW-1], s_area_r.y});
  assign wx      = $signed({s_win_r.x[CW-1], s_win_r.x});
  assign wy      = $signed({s_win_r.y[CW-1], s_win_r.y});
  assign cen_x   = ax + $signed({{(RW-SW+1){1'b0}}, slack_w[SW-1:1]});
  assign cen_y   = ay + $signed({{(RW-SW+1){1'b0}}, slack_h[SW-1:1]});
  assign hi_x    = ax + $signed({{(RW-SW){1'b0}}, slack_w});
  assign hi_y    = ay + $signed({{(RW-SW){1'b0}}, slack_h});
  assign lo_x    = (wx > ax) ? wx : ax;
  assign lo_y    = (wy > ay) ? wy : ay;
  assign fit_x   = s_zero_r ? cen_x : ((lo_x < hi_x) ? lo_x : hi_x);
  assign fit_y   = s_zero_r ? cen_y : ((lo_y < hi_y) ? lo_y : hi_y);

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_w         = out_w_r;
  assign out_h         = out_h_r;
  assign out_maximized = out_max_r;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      have_best_r <= 1'b0;
    end else begin
      have_best_r <= have_best_nxt;
      if (advance) begin
        win_r       <= win_nxt;
        a_valid_r   <= q_valid;
        b_valid_r   <= a_valid_r;
        s_valid_r   <= b_valid_r && b_last_r;
        out_valid_r <= s_valid_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    best_ov_r   <= best_ov_nxt;
    best_dist_r <= best_dist_nxt;
    best_area_r <= best_area_nxt;
    if (advance) begin
      // Geometry stage
      a_op_r       <= q_item.op;
      a_last_r     <= q_item.last;
      a_ow_r       <= overlap ? span_x[SW-1:0] : '0;
      a_oh_r       <= overlap ? span_y[SW-1:0] : '0;
      a_ux_r       <= adx[DFW-1:0];
      a_uy_r       <= ady[DFW-1:0];
      a_area_r.x   <= q_px;
      a_area_r.y   <= q_py;
      a_area_r.w   <= q_ew[SW-1:0];
      a_area_r.h   <= q_eh[SW-1:0];
      a_win_r      <= win_nxt;
      // Multiply stage
      b_op_r       <= a_op_r;
      b_last_r     <= a_last_r;
      b_ov_r       <= OVW'(a_ow_r) * OVW'(a_oh_r);
      b_sqx_r      <= DSW'(a_ux_r) * DSW'(a_ux_r);
      b_sqy_r      <= DSW'(a_uy_r) * DSW'(a_uy_r);
      b_area_r     <= a_area_r;
      b_win_r      <= a_win_r;
      // Snapshot for the result
      s_ok_r       <= b_win_r.sane && cur_have;
      s_zero_r     <= (cur_ov == '0);
      s_area_r     <= cur_area;
      s_win_r      <= b_win_r;
      // Output word; an invalid result carries zeros
      out_ok_r     <= s_ok_r;
      out_x_r      <= s_ok_r ? fit_x : '0;
      out_y_r      <= s_ok_r ? fit_y : '0;
      out_w_r      <= s_ok_r ? r_w : '0;
      out_h_r      <= s_ok_r ? r_h : '0;
      out_max_r    <= s_ok_r && s_win_r.maxf;
    end
  end

endmodule

// ===== rtl/window_placement_fit_to_monitor.sv =====
// Top level of the window placement fitter: front, word queue and back.
// Depends on wpf_pkg, wpf_front, wpf_queue and wpf_back.
//
//   channel | ports                                   | word
//   --------+-----------------------------------------+------------------------------
//   input   | in_valid / in_stall                     | kind, rect, maximized, last
//   result  | out_valid / out_stall                   | ok, out_x/out_y, out_w/out_h
//   config  | cfg_we, cfg_index, cfg_wdata            | min_width, min_height
//
// One input word is accepted per cycle while in_stall is low; the word with last
// passes the front hold, queue, geometry, multiply, snapshot and output registers.
// The rate is set by the best-area compare and update in the back's select stage.
// Reset (rst_n low at a clock edge) empties the queue and pipeline, clears the
// stored window and search, and loads the limit registers with 320 and 200.
// A held result stops the back pipeline; the queue then absorbs input until full.
module window_placement_fit_to_monitor #(
  parameter int unsigned QueueDepth = wpf_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpf_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic signed [wpf_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [wpf_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [wpf_pkg::EXT_W-1:0]   in_extent_w,
  input  logic signed [wpf_pkg::EXT_W-1:0]   in_extent_h,
  input  logic                               in_is_maximized,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_ok,
  output logic signed [wpf_pkg::RES_W-1:0]   out_x,
  output logic signed [wpf_pkg::RES_W-1:0]   out_y,
  output logic [wpf_pkg::SIZE_W-1:0]         out_w,
  output logic [wpf_pkg::SIZE_W-1:0]         out_h,
  output logic                               out_maximized
);

  logic           push_valid;
  wpf_pkg::item_t push_item;
  logic           queue_full;
  logic           q_pop;
  logic           q_valid;
  wpf_pkg::item_t q_item;

  // Accept and classify
  wpf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_extent_w    (in_extent_w),
    .in_extent_h    (in_extent_h),
    .in_is_maximized(in_is_maximized),
    .in_last        (in_last),
    .push_valid     (push_valid),
    .push_item      (push_item),
    .queue_full     (queue_full)
  );

  // Decouple front and back
  wpf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  // Search and form the result
  wpf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_w        (out_w),
    .out_h        (out_h),
    .out_maximized(out_maximized)
  );

endmodule
